FILE: rtl/tmfd_pkg.sv
package tmfd_pkg;

  localparam logic [3:0] KIND_INT8  = 4'd0;
  localparam logic [3:0] KIND_INT16 = 4'd1;
  localparam logic [3:0] KIND_INT32 = 4'd2;
  localparam logic [3:0] KIND_INT64 = 4'd3;
  localparam logic [3:0] KIND_UINT8 = 4'd4;
  localparam logic [3:0] KIND_UINT16 = 4'd5;
  localparam logic [3:0] KIND_UINT32 = 4'd6;
  localparam logic [3:0] KIND_UINT64 = 4'd7;
  localparam logic [3:0] KIND_F32   = 4'd8;
  localparam logic [3:0] KIND_F64   = 4'd9;
  localparam logic [3:0] KIND_BOOL  = 4'd10;

  // quotient bits, one per divider stage
  localparam int QBITS = 64;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV0     = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_NOTPRIM  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SP_NONE = 2'd0,
    SP_NAN  = 2'd1,
    SP_INF  = 2'd2,
    SP_ZERO = 2'd3
  } spec_t;

  typedef struct packed {
    logic [3:0]         kind;
    status_t            status;
    spec_t              spec;
    logic               sign;
    logic signed [13:0] exp;
    logic               neg;
  } meta_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] nq;   // numerator bits shift out, quotient bits shift in
    logic [63:0] den;
  } dstate_t;

  function automatic logic [63:0] kind_mask(input logic [3:0] kind);
    logic [63:0] m;
    unique case (kind)
      KIND_INT8, KIND_UINT8:   m = 64'h0000_0000_0000_00FF;
      KIND_INT16, KIND_UINT16: m = 64'h0000_0000_0000_FFFF;
      KIND_INT32, KIND_UINT32: m = 64'h0000_0000_FFFF_FFFF;
      KIND_INT64, KIND_UINT64: m = 64'hFFFF_FFFF_FFFF_FFFF;
      KIND_BOOL:               m = 64'h0000_0000_0000_0001;
      default:                 m = 64'h0;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] lzc53(input logic [52:0] m);
    logic [5:0] cnt;
    cnt = 6'd53;
    for (int i = 0; i < 53; i++) begin
      if (m[i]) cnt = 6'(52 - i);
    end
    return cnt;
  endfunction

endpackage

FILE: rtl/tmfd_front.sv
module tmfd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [3:0]        in_left_kind,
  input  logic [3:0]        in_right_kind,
  input  logic [63:0]       in_dividend,
  input  logic [63:0]       in_divisor,
  output logic              d_valid,
  output tmfd_pkg::meta_t   d_meta,
  output tmfd_pkg::dstate_t d_state
);
  import tmfd_pkg::*;

  // stage 0: captured word
  logic        v0_r;
  logic [3:0]  lk0_r, rk0_r;
  logic [63:0] a0_r, b0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
    if (adv) begin
      lk0_r <= in_left_kind;
      rk0_r <= in_right_kind;
      a0_r  <= in_dividend;
      b0_r  <= in_divisor;
    end
  end

  // decode and unpack
  logic [63:0] msk, am, bm, sbit, sxa, sxb, maga, magb;
  logic        is_sig, nega, negb, is64, isflt;
  logic [10:0] ea, eb, emax;
  logic [51:0] fa, fb;
  logic        sga, sgb;
  logic signed [13:0] bias, exa, exb;
  logic        zra, zrb, nana, nanb, infa, infb;
  meta_t       meta0;

  always_comb begin
    msk    = kind_mask(lk0_r);
    am     = a0_r & msk;
    bm     = b0_r & msk;
    sbit   = msk ^ (msk >> 1);
    is_sig = (lk0_r[3:2] == 2'b00);
    nega   = is_sig && ((am & sbit) != 64'd0);
    negb   = is_sig && ((bm & sbit) != 64'd0);
    sxa    = nega ? (am | ~msk) : am;
    sxb    = negb ? (bm | ~msk) : bm;
    maga   = nega ? (64'd0 - sxa) : sxa;
    magb   = negb ? (64'd0 - sxb) : sxb;

    is64   = (lk0_r == KIND_F64);
    isflt  = (lk0_r == KIND_F32) || is64;
    ea     = is64 ? a0_r[62:52] : {3'b000, a0_r[30:23]};
    eb     = is64 ? b0_r[62:52] : {3'b000, b0_r[30:23]};
    fa     = is64 ? a0_r[51:0] : {a0_r[22:0], 29'd0};
    fb     = is64 ? b0_r[51:0] : {b0_r[22:0], 29'd0};
    sga    = is64 ? a0_r[63] : a0_r[31];
    sgb    = is64 ? b0_r[63] : b0_r[31];
    emax   = is64 ? 11'h7FF : 11'h0FF;
    bias   = is64 ? 14'sd1023 : 14'sd127;
    exa    = signed'({3'b000, (ea == 11'd0) ? 11'd1 : ea}) - bias;
    exb    = signed'({3'b000, (eb == 11'd0) ? 11'd1 : eb}) - bias;
    zra    = (ea == 11'd0) && (fa == 52'd0);
    zrb    = (eb == 11'd0) && (fb == 52'd0);
    nana   = (ea == emax) && (fa != 52'd0);
    nanb   = (eb == emax) && (fb != 52'd0);
    infa   = (ea == emax) && (fa == 52'd0);
    infb   = (eb == emax) && (fb == 52'd0);

    meta0      = '0;
    meta0.kind = lk0_r;
    meta0.sign = sga ^ sgb;
    meta0.neg  = nega ^ negb;
    if (lk0_r != rk0_r) begin
      meta0.status = ST_MISMATCH;
    end else if (lk0_r > KIND_BOOL) begin
      meta0.status = ST_NOTPRIM;
    end else if (isflt ? zrb : (bm == 64'd0)) begin
      meta0.status = ST_DIV0;
    end else begin
      meta0.status = ST_OK;
    end
    priority if (nana || nanb || (infa && infb)) begin
      meta0.spec = SP_NAN;
    end else if (infa) begin
      meta0.spec = SP_INF;
    end else if (infb || zra) begin
      meta0.spec = SP_ZERO;
    end else begin
      meta0.spec = SP_NONE;
    end
  end

  // stage 1: unpacked operands and leading-zero counts
  logic               v1_r, isflt1_r;
  meta_t              meta1_r;
  logic [52:0]        ma1_r, mb1_r;
  logic [5:0]         lza1_r, lzb1_r;
  logic signed [13:0] ea1_r, eb1_r;
  logic [63:0]        maga1_r, magb1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
    if (adv) begin
      isflt1_r <= isflt;
      meta1_r  <= meta0;
      ma1_r    <= {ea != 11'd0, fa};
      mb1_r    <= {eb != 11'd0, fb};
      lza1_r   <= lzc53({ea != 11'd0, fa});
      lzb1_r   <= lzc53({eb != 11'd0, fb});
      ea1_r    <= exa;
      eb1_r    <= exb;
      maga1_r  <= maga;
      magb1_r  <= magb;
    end
  end

  // normalize float mantissas and line up the dividend so the quotient lands in [1,2); ints pass magnitudes
  logic [52:0]        nma, nmb;
  logic               lt;
  logic [53:0]        ma54;
  logic signed [13:0] eq;
  meta_t              meta1;
  dstate_t            st1;

  always_comb begin
    nma  = ma1_r << lza1_r;
    nmb  = mb1_r << lzb1_r;
    lt   = nma < nmb;
    ma54 = lt ? {nma, 1'b0} : {1'b0, nma};
    eq   = ea1_r - signed'({8'd0, lza1_r}) - eb1_r + signed'({8'd0, lzb1_r})
           - signed'({13'd0, lt});
    meta1     = meta1_r;
    meta1.exp = eq;
    if (isflt1_r) begin
      st1.rem = {11'd0, ma54[53:1]};
      st1.nq  = {ma54[0], 63'd0};
      st1.den = {11'd0, nmb};
    end else begin
      st1.rem = 64'd0;
      st1.nq  = maga1_r;
      st1.den = magb1_r;
    end
  end

  logic    v2_r;
  meta_t   meta2_r;
  dstate_t st2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      meta2_r <= meta1;
      st2_r   <= st1;
    end
  end

  assign d_valid = v2_r;
  assign d_meta  = meta2_r;
  assign d_state = st2_r;

endmodule

FILE: rtl/tmfd_div_stage.sv
module tmfd_div_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              i_valid,
  input  tmfd_pkg::meta_t   i_meta,
  input  tmfd_pkg::dstate_t i_state,
  output logic              o_valid,
  output tmfd_pkg::meta_t   o_meta,
  output tmfd_pkg::dstate_t o_state
);
  import tmfd_pkg::*;

  logic [64:0] trial, diff;
  logic        ge;
  dstate_t     nxt;

  // one restoring step: bring down a bit, subtract if it fits
  always_comb begin
    trial   = {i_state.rem, i_state.nq[63]};
    diff    = trial - {1'b0, i_state.den};
    ge      = trial >= {1'b0, i_state.den};
    nxt.rem = ge ? diff[63:0] : trial[63:0];
    nxt.nq  = {i_state.nq[62:0], ge};
    nxt.den = i_state.den;
  end

  logic    valid_r;
  meta_t   meta_r;
  dstate_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= i_valid;
    end
    if (adv) begin
      meta_r  <= i_meta;
      state_r <= nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_meta  = meta_r;
  assign o_state = state_r;

endmodule

FILE: rtl/tmfd_round.sv
module tmfd_round (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              i_valid,
  input  tmfd_pkg::meta_t   i_meta,
  input  tmfd_pkg::dstate_t i_state,
  output logic              out_valid,
  output logic [63:0]       out_quotient,
  output logic [3:0]        out_result_kind,
  output logic [1:0]        out_status
);
  import tmfd_pkg::*;

  logic [63:0]        q, qsh, lmask, qi, val;
  logic               is64, isflt, ovf, sub, big, lost, stk;
  logic signed [13:0] bias, be, samt;
  logic [5:0]         sh;
  logic [10:0]        base;

  // exponent, denormalizing right shift and its sticky bit; integers get their sign back
  always_comb begin
    q     = i_state.nq;
    is64  = (i_meta.kind == KIND_F64);
    isflt = (i_meta.kind == KIND_F32) || is64;
    bias  = is64 ? 14'sd1023 : 14'sd127;
    be    = i_meta.exp + bias;
    ovf   = is64 ? (be >= 14'sd2047) : (be >= 14'sd255);
    sub   = be < 14'sd1;
    samt  = 14'sd1 - be;
    big   = sub && (samt > 14'sd63);
    sh    = sub ? samt[5:0] : 6'd0;
    lmask = ~(~64'd0 << sh);
    qsh   = big ? 64'd0 : (q >> sh);
    lost  = big ? (q != 64'd0) : ((q & lmask) != 64'd0);
    stk   = (i_state.rem != 64'd0) || lost;
    base  = sub ? 11'd0 : (be[10:0] - 11'd1);
    qi    = i_meta.neg ? (64'd0 - q) : q;
    val   = isflt ? qsh : qi;
  end

  logic        v_r, stk_r, ovf_r;
  meta_t       meta_r;
  logic [63:0] val_r;
  logic [10:0] base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= i_valid;
    end
    if (adv) begin
      meta_r <= i_meta;
      val_r  <= val;
      stk_r  <= stk;
      ovf_r  <= ovf;
      base_r <= base;
    end
  end

  // round to nearest even and pack; error words give zero, integers are masked to their kind
  logic        r64, r32, up64, up32;
  logic [63:0] res64, res;
  logic [31:0] res32;

  always_comb begin
    r64   = (val_r[9:0] != 10'd0) || stk_r;
    up64  = val_r[10] && (r64 || val_r[11]);
    res64 = {1'b0, base_r, 52'd0} + {11'd0, val_r[63:11]} + {63'd0, up64};
    r32   = (val_r[38:0] != 39'd0) || stk_r;
    up32  = val_r[39] && (r32 || val_r[40]);
    res32 = {1'b0, base_r[7:0], 23'd0} + {8'd0, val_r[63:40]} + {31'd0, up32};
    res   = 64'd0;
    if (meta_r.status != ST_OK) begin
      res = 64'd0;
    end else if (meta_r.kind == KIND_F64) begin
      unique case (meta_r.spec)
        SP_NAN:  res = 64'h7FF8_0000_0000_0000;
        SP_INF:  res = {meta_r.sign, 11'h7FF, 52'd0};
        SP_ZERO: res = {meta_r.sign, 63'd0};
        default: res = ovf_r ? {meta_r.sign, 11'h7FF, 52'd0} : {meta_r.sign, res64[62:0]};
      endcase
    end else if (meta_r.kind == KIND_F32) begin
      unique case (meta_r.spec)
        SP_NAN:  res = 64'h0000_0000_7FC0_0000;
        SP_INF:  res = {32'd0, meta_r.sign, 8'hFF, 23'd0};
        SP_ZERO: res = {32'd0, meta_r.sign, 31'd0};
        default: res = ovf_r ? {32'd0, meta_r.sign, 8'hFF, 23'd0}
                             : {32'd0, meta_r.sign, res32[30:0]};
      endcase
    end else begin
      res = val_r & kind_mask(meta_r.kind);
    end
  end

  logic        ov_r;
  logic [63:0] oq_r;
  logic [3:0]  ok_r;
  status_t     os_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= v_r;
    end
    if (adv) begin
      oq_r <= res;
      ok_r <= meta_r.kind;
      os_r <= meta_r.status;
    end
  end

  assign out_valid       = ov_r;
  assign out_quotient    = oq_r;
  assign out_result_kind = ok_r;
  assign out_status      = os_r;

endmodule

FILE: rtl/typed_multi_format_divider.sv
// throughput: one word per cycle unless out_valid is held by out_stall
// a 64-stage restoring divider, one quotient bit per stage
// a stalled output freezes the whole pipeline and holds in_stall high
// reset: synchronous active-low rst_n clears every stage valid bit, no payload reset
module typed_multi_format_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_left_kind,
  input  logic [3:0]  in_right_kind,
  input  logic [63:0] in_dividend,
  input  logic [63:0] in_divisor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_quotient,
  output logic [3:0]  out_result_kind,
  output logic [1:0]  out_status
);
  import tmfd_pkg::*;

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  logic    dv [QBITS+1];
  meta_t   dm [QBITS+1];
  dstate_t ds [QBITS+1];

  tmfd_front u_front (
    .clk, .rst_n, .adv,
    .in_valid, .in_left_kind, .in_right_kind, .in_dividend, .in_divisor,
    .d_valid(dv[0]), .d_meta(dm[0]), .d_state(ds[0])
  );

  for (genvar g = 0; g < QBITS; g++) begin : g_div
    tmfd_div_stage u_stage (
      .clk, .rst_n, .adv,
      .i_valid(dv[g]),   .i_meta(dm[g]),   .i_state(ds[g]),
      .o_valid(dv[g+1]), .o_meta(dm[g+1]), .o_state(ds[g+1])
    );
  end

  tmfd_round u_round (
    .clk, .rst_n, .adv,
    .i_valid(dv[QBITS]), .i_meta(dm[QBITS]), .i_state(ds[QBITS]),
    .out_valid, .out_quotient, .out_result_kind, .out_status
  );

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_quotient == 64'd0)
    else $error("error word carries a nonzero quotient");

  a_f32_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_F32) |-> out_quotient[63:32] == 32'd0)
    else $error("f32 quotient not zero-extended");

  a_byte_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_result_kind == KIND_INT8) || (out_result_kind == KIND_UINT8))
    |-> out_quotient[63:8] == 56'd0)
    else $error("byte quotient not zero-extended");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked output");

endmodule
